FILE: design/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants for the linear-scan max-priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

    // Default number of entries the store holds
    localparam int CAPACITY_DEF = 1024;

    // Width of one held value
    localparam int VALUE_W = 32;

    // Operation codes on the input channel
    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    // Memory access strobes from the sequencer to the store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    // Result of one operation, excluding the fill level
    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] removed;
    } res_t;

endpackage

FILE: design/mpq_store.sv
// ----------------------------------------------------------------------------
// mpq_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mpq_store #(
    parameter int CAPACITY = mpq_pkg::CAPACITY_DEF,
    parameter int ADDR_W   = $clog2(CAPACITY)
) (
    input  logic                        aclk,
    input  mpq_pkg::mem_ctl_t           mem_ctl,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [mpq_pkg::VALUE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [mpq_pkg::VALUE_W-1:0] rd_data
);
    import mpq_pkg::*;

    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (mem_ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge aclk) begin
        if (mem_ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/mpq_ctrl.sv
// ----------------------------------------------------------------------------
// mpq_ctrl
// Operation sequencer: append on insert; on extract, scan held entries one
// read a cycle, keep the first largest, move the last entry into its slot.
// ----------------------------------------------------------------------------
module mpq_ctrl #(
    parameter int CAPACITY = mpq_pkg::CAPACITY_DEF,
    parameter int ADDR_W   = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // operation beat
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_func,
    input  logic [mpq_pkg::VALUE_W-1:0] in_value,
    // result beat
    output logic                        res_valid,
    input  logic                        res_ready,
    output mpq_pkg::res_t               res,
    output logic [CNT_W-1:0]            res_count,
    // store access
    output mpq_pkg::mem_ctl_t           mem_ctl,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [mpq_pkg::VALUE_W-1:0] wr_data,
    output logic [ADDR_W-1:0]           rd_addr,
    input  logic [mpq_pkg::VALUE_W-1:0] rd_data
);
    import mpq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0]                state_reg,    state_next;
    logic [CNT_W-1:0]          count_reg,    count_next;
    logic [ADDR_W-1:0]         cmp_idx_reg,  cmp_idx_next;
    logic [ADDR_W-1:0]         best_idx_reg, best_idx_next;
    logic signed [VALUE_W-1:0] best_val_reg, best_val_next;
    res_t                      res_reg,      res_next;

    logic [CNT_W-1:0]  count_dec;
    logic [ADDR_W-1:0] last_idx;
    logic              is_full;
    logic              is_empty;
    logic              take;
    logic [ADDR_W-1:0] cand_idx;
    logic [VALUE_W-1:0] cand_val;

    assign count_dec = count_reg - CNT_W'(1);
    assign last_idx  = count_dec[ADDR_W-1:0];
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);

    // Running maximum: first entry seeds it, later ones win only if strictly greater
    assign take     = (cmp_idx_reg == '0) || ($signed(rd_data) > best_val_reg);
    assign cand_idx = take ? cmp_idx_reg : best_idx_reg;
    assign cand_val = take ? rd_data : best_val_reg;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        cmp_idx_next  = cmp_idx_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        res_next      = res_reg;
        mem_ctl       = '0;
        wr_addr       = count_reg[ADDR_W-1:0];
        wr_data       = in_value;
        rd_addr       = '0;
        in_ready      = 1'b0;
        res_valid     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    res_next.removed = '0;
                    res_next.ok      = 1'b0;
                    if (in_func == FUNC_INSERT) begin
                        state_next = ST_RESP;
                        if (!is_full) begin
                            mem_ctl.wr_en = 1'b1;
                            count_next    = count_reg + CNT_W'(1);
                            res_next.ok   = 1'b1;
                        end
                    end else if (is_empty) begin
                        state_next = ST_RESP;
                    end else begin
                        // first read of the scan
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = '0;
                        cmp_idx_next  = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                best_idx_next = cand_idx;
                best_val_next = cand_val;
                if (cmp_idx_reg == last_idx) begin
                    // last entry fills the freed slot
                    mem_ctl.wr_en    = 1'b1;
                    wr_addr          = cand_idx;
                    wr_data          = rd_data;
                    count_next       = count_dec;
                    res_next.ok      = 1'b1;
                    res_next.removed = cand_val;
                    state_next       = ST_RESP;
                end else begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = cmp_idx_reg + ADDR_W'(1);
                    cmp_idx_next  = cmp_idx_reg + ADDR_W'(1);
                end
            end
            ST_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Scan and result payload
    always_ff @(posedge aclk) begin
        cmp_idx_reg  <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        res_reg      <= res_next;
    end

    assign res       = res_reg;
    assign res_count = count_reg;

    // Fill level stays within the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill level beyond capacity");

    // Scan index stays below the fill level
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (CNT_W'(cmp_idx_reg) < count_reg))
        else $error("scan index past last held entry");

    // Store writes only on an accepted insert or at the end of a scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_ctl.wr_en |-> ((state_reg == ST_IDLE && in_valid) || state_reg == ST_SCAN))
        else $error("unexpected store write");

    // Successful insert raises the fill level by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && in_valid && in_func == FUNC_INSERT && !is_full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance fill level");

    // Extract that finishes its scan lowers the fill level by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && cmp_idx_reg == last_idx)
        |=> (count_reg == $past(count_dec)))
        else $error("extract did not reduce fill level");

endmodule

FILE: design/max_priority_queue_linear_scan.sv
// ----------------------------------------------------------------------------
// max_priority_queue_linear_scan
// Bounded max-priority queue kept as an unsorted array in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): s_func selects insert (append s_new_value) or
//   extract (remove the largest held value, first one on ties).
//   Result channel (m_*): one beat per operation with m_ok, the removed value
//   (zero unless an extract succeeded) and the fill level afterwards.
//   Operations are handled one at a time. An insert or a failed operation
//   goes from acceptance straight to the result state. A successful
//   extract first scans each held entry in turn, each memory read issued
//   in the cycle before its compare, and the move of the last entry is
//   written back in the final scan cycle. The next operation is taken in
//   the cycle after the result is handed on. The result sits in an
//   output register; a stalled receiver holds it there. The next operation
//   is still taken, and its result waits in the sequencer until that
//   register can accept it.
//   Reset empties the queue at once; memory contents need no clearing since
//   only entries below the fill level are ever read.
// ----------------------------------------------------------------------------
module max_priority_queue_linear_scan #(
    parameter int CAPACITY = mpq_pkg::CAPACITY_DEF,
    parameter int ADDR_W   = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // operation channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic signed [mpq_pkg::VALUE_W-1:0] s_new_value,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_ok,
    output logic signed [mpq_pkg::VALUE_W-1:0] m_removed_value,
    output logic [CNT_W-1:0]                   m_entries_held
);
    import mpq_pkg::*;

    mem_ctl_t           mem_ctl;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic [VALUE_W-1:0] rd_data;

    logic               res_valid;
    logic               res_ready;
    res_t               res;
    logic [CNT_W-1:0]   res_count;

    logic               m_valid_reg;
    logic               m_ok_reg;
    logic [VALUE_W-1:0] m_removed_reg;
    logic [CNT_W-1:0]   m_held_reg;

    mpq_ctrl #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_func   (s_func),
        .in_value  (s_new_value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .res_count (res_count),
        .mem_ctl   (mem_ctl),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    mpq_store #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register takes a result when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_ok_reg      <= res.ok;
            m_removed_reg <= res.removed;
            m_held_reg    <= res_count;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_ok            = m_ok_reg;
    assign m_removed_value = m_removed_reg;
    assign m_entries_held  = m_held_reg;

endmodule
